// File: sv/qrts_pkg.sv
// Shared types and constants for the qubit ready time scheduler.
// Used by qrts_front, qrts_queue, qrts_back and the top level.
package qrts_pkg;

  localparam int QUBIT_COUNT   = 32;
  localparam int CLBIT_COUNT   = 32;
  localparam int TIME_BITS     = 32;
  localparam int DURATION_BITS = 16;

  // Only the first 32 qubits / clbits are addressable by the instruction fields
  localparam int QB_USED = (QUBIT_COUNT < 32) ? QUBIT_COUNT : 32;
  localparam int CB_USED = (CLBIT_COUNT < 32) ? CLBIT_COUNT : 32;

  // Leaves of the masked max tree, rounded up to a power of two
  localparam int QB_TREE_N = 1 << $clog2(QB_USED);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the config port
  localparam logic [2:0] CFG_DEPTH_MODE = 3'd0;
  localparam logic [2:0] CFG_DUR_0_3    = 3'd1;
  localparam logic [2:0] CFG_DUR_4_7    = 3'd2;
  localparam logic [2:0] CFG_DUR_8_11   = 3'd3;
  localparam logic [2:0] CFG_DUR_12     = 3'd4;
  localparam logic [2:0] CFG_KNOWN_MASK = 3'd5;

  localparam logic [3:0] OP_MEASURE = 4'd10;
  localparam logic [3:0] OP_BARRIER = 4'd12;

  typedef logic [TIME_BITS-1:0]     time_t;
  typedef logic [DURATION_BITS-1:0] dur_t;

  // Decoded instruction, front to back
  typedef struct packed {
    logic               first;
    logic               barrier;
    logic               measure;
    logic [QB_USED-1:0] mask;
    logic               has_cond;
    logic [4:0]         cond_bit;
    logic [4:0]         meas_bit;
    dur_t               dur;
    logic               missing;
  } item_t;

  // Scheduled result, back to output packing
  typedef struct packed {
    logic [15:0] instr_index;
    logic        is_scheduled;
    time_t       start_time;
    dur_t        op_duration;
    time_t       end_time;
    time_t       total_time;
    logic        duration_missing;
    logic        time_overflow;
  } res_t;

endpackage

// File: sv/qrts_front.sv
// Front end: config registers, input handshake and instruction decode.
// Depends on qrts_pkg.
module qrts_front import qrts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_first_i,
  input  logic [47:0] in_data_i,
  input  logic        q_full_i,
  output logic        in_ready_o,
  output logic        push_o,
  output item_t       item_o
);

  logic        depth_mode_q;
  logic [63:0] dur_lo_q, dur_mid_q, dur_hi_q;
  logic [12:0] known_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q <= 1'b1;
      dur_lo_q     <= '0;
      dur_mid_q    <= '0;
      dur_hi_q     <= '0;
      known_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEPTH_MODE: depth_mode_q <= cfg_data_i[0];
        CFG_DUR_0_3:    dur_lo_q     <= cfg_data_i;
        CFG_DUR_4_7:    dur_mid_q    <= cfg_data_i;
        CFG_DUR_8_11:   dur_hi_q     <= cfg_data_i;
        CFG_KNOWN_MASK: known_q      <= cfg_data_i[12:0];
        // opcode 12 duration has no effect (barriers take no time)
        default: ;
      endcase
    end
  end

  logic [3:0]  op;
  logic [63:0] word;
  logic [15:0] lane;
  logic [15:0] known_ext;
  logic        is_barrier, has_dur;

  assign op         = in_data_i[3:0];
  assign is_barrier = (op == OP_BARRIER);
  assign known_ext  = {3'b000, known_q};
  assign has_dur    = (op < OP_BARRIER) && known_ext[op];

  always_comb begin
    unique case (op[3:2])
      2'd0:    word = dur_lo_q;
      2'd1:    word = dur_mid_q;
      2'd2:    word = dur_hi_q;
      default: word = '0;
    endcase
    unique case (op[1:0])
      2'd0:    lane = word[15:0];
      2'd1:    lane = word[31:16];
      2'd2:    lane = word[47:32];
      default: lane = word[63:48];
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o          = '0;
    item_o.first    = in_first_i;
    item_o.barrier  = is_barrier;
    item_o.measure  = (op == OP_MEASURE);
    item_o.mask     = in_data_i[4 +: QB_USED];
    item_o.has_cond = in_data_i[36];
    item_o.cond_bit = in_data_i[41:37];
    item_o.meas_bit = in_data_i[46:42];
    if (is_barrier) begin
      item_o.dur = '0;
    end else if (depth_mode_q) begin
      item_o.dur = DURATION_BITS'(1);
    end else if (has_dur) begin
      item_o.dur = lane[DURATION_BITS-1:0];
    end else begin
      item_o.dur     = '0;
      item_o.missing = 1'b1;
    end
  end

endmodule

// File: sv/qrts_queue.sv
// Short FIFO of decoded instructions between front and back end.
// Depends on qrts_pkg.
module qrts_queue import qrts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  function automatic logic [QPTR_BITS-1:0] nxt(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/qrts_back.sv
// Back end: ready time scoreboard, ASAP start, saturating end, output register.
// Depends on qrts_pkg.
module qrts_back import qrts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  time_t       qrt_q [QB_USED];
  time_t       crt_q [CB_USED];
  time_t       total_q;
  logic [15:0] idx_q;
  logic        miss_q, ovf_q;
  logic        out_valid_q;
  res_t        res_q;

  time_t       qrt_eff [QB_USED];
  time_t       crt_eff [CB_USED];
  time_t       tree [QB_TREE_N];
  time_t       total_eff, mx, cond_t, start, fin, total_d;
  logic [TIME_BITS:0] sum;
  logic [15:0] idx_eff;
  logic        miss_eff, ovf_eff, ovf_now, fire;

  assign fire  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire;

  // first_of_circuit clears everything before the item is scheduled
  always_comb begin
    for (int q = 0; q < QB_USED; q++) begin
      qrt_eff[q] = item_i.first ? '0 : qrt_q[q];
    end
    for (int c = 0; c < CB_USED; c++) begin
      crt_eff[c] = item_i.first ? '0 : crt_q[c];
    end
    total_eff = item_i.first ? '0 : total_q;
    idx_eff   = item_i.first ? '0 : idx_q;
    miss_eff  = item_i.first ? 1'b0 : miss_q;
    ovf_eff   = item_i.first ? 1'b0 : ovf_q;
  end

  // masked max, balanced compare tree
  always_comb begin
    for (int i = 0; i < QB_TREE_N; i++) begin
      tree[i] = '0;
      if (i < QB_USED) begin
        if (item_i.mask[i]) tree[i] = qrt_eff[i];
      end
    end
    for (int w = QB_TREE_N / 2; w >= 1; w = w / 2) begin
      for (int i = 0; i < w; i++) begin
        tree[i] = (tree[2*i] > tree[2*i+1]) ? tree[2*i] : tree[2*i+1];
      end
    end
    mx = tree[0];
  end

  always_comb begin
    cond_t = '0;
    for (int c = 0; c < CB_USED; c++) begin
      if (item_i.cond_bit == 5'(c)) cond_t = crt_eff[c];
    end
    start = mx;
    if (!item_i.barrier && item_i.has_cond && (cond_t > mx)) start = cond_t;
    sum     = {1'b0, start} + (TIME_BITS+1)'(item_i.dur);
    ovf_now = !item_i.barrier && sum[TIME_BITS];
    if (item_i.barrier) begin
      fin = start;
    end else if (ovf_now) begin
      fin = '1;
    end else begin
      fin = sum[TIME_BITS-1:0];
    end
    total_d = (fin > total_eff) ? fin : total_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < QB_USED; q++) qrt_q[q] <= '0;
      for (int c = 0; c < CB_USED; c++) crt_q[c] <= '0;
      total_q <= '0;
      idx_q   <= '0;
      miss_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (fire) begin
      for (int q = 0; q < QB_USED; q++) begin
        qrt_q[q] <= item_i.mask[q] ? fin : qrt_eff[q];
      end
      for (int c = 0; c < CB_USED; c++) begin
        crt_q[c] <= (item_i.measure && item_i.meas_bit == 5'(c)) ? fin : crt_eff[c];
      end
      total_q <= total_d;
      idx_q   <= idx_eff + 16'd1;
      miss_q  <= miss_eff | item_i.missing;
      ovf_q   <= ovf_eff | ovf_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.instr_index      <= idx_eff;
      res_q.is_scheduled     <= !item_i.barrier;
      res_q.start_time       <= start;
      res_q.op_duration      <= item_i.dur;
      res_q.end_time         <= fin;
      res_q.total_time       <= total_d;
      res_q.duration_missing <= miss_eff | item_i.missing;
      res_q.time_overflow    <= ovf_eff | ovf_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/qubit_ready_time_scheduler_unit.sv
// Top level of the ASAP qubit ready time scheduler.
// Depends on qrts_pkg, qrts_front, qrts_queue and qrts_back.
//
//  channel | dir | valid/ready                    | payload
//  --------+-----+--------------------------------+-------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata 48b, tuser first_of_circuit
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata 136b, tuser is_scheduled
//  cfg     | in  | cfg_we_i (no ready)            | cfg_index_i, cfg_data_i 64b
//
// Throughput is one instruction per clock while the output is not stalled; the
// limit is the scoreboard loop in qrts_back (masked max tree over the qubit
// ready times, then one add). An input beat is registered in the queue, then in
// the back end's output register, before it leaves as an output beat.
// Reset clears scoreboard, total, index and flags and loads depth mode; no
// clearing pass is needed. The two-entry queue lets the input keep taking beats
// while the output is stalled, until the queue is full.
module qubit_ready_time_scheduler_unit import qrts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] op_code, [35:4] qubit_mask, [36] has_condition,
  // [41:37] condition_bit, [46:42] measure_clbit, [47] zero
  input  logic [47:0]  s_axis_tdata,
  // [0] first_of_circuit
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] instr_index, [47:16] start_time, [63:48] op_duration,
  // [95:64] end_time, [127:96] total_time, [128] duration_missing,
  // [129] time_overflow, [135:130] zero
  output logic [135:0] m_axis_tdata,
  // [0] is_scheduled
  output logic         m_axis_tuser
);

  item_t front_item, q_item;
  res_t  res;
  logic  push, pop, q_full, q_valid;

  qrts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_first_i  (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .item_o      (front_item)
  );

  qrts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  qrts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // times leave in 32 bits whatever the internal width
  assign m_axis_tdata = {6'b000000,
                         res.time_overflow,
                         res.duration_missing,
                         32'(res.total_time),
                         32'(res.end_time),
                         16'(res.op_duration),
                         32'(res.start_time),
                         res.instr_index};
  assign m_axis_tuser = res.is_scheduled;

endmodule
